>>> rtl/core/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the byte pattern scanner.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned NEEDLE_MAX  = 32;
  localparam int unsigned HIST_DEPTH  = 32;
  localparam int unsigned MATCH_LIMIT = 16;
  localparam int unsigned FIFO_DEPTH  = 3;

  localparam logic [31:0] FLASH_BASE  = 32'h1000_0000;
  localparam logic [8:0]  PAYLOAD_LO  = 9'd32;
  localparam logic [8:0]  PAYLOAD_HI  = 9'd288;
  localparam logic [4:0]  TOTAL_SAT   = 5'd31;
  localparam logic [5:0]  FILL_FULL   = 6'(HIST_DEPTH);
  localparam logic [5:0]  LEN_MAX     = 6'(NEEDLE_MAX);

  typedef enum logic [2:0] {
    CFG_NEEDLE_A   = 3'd0,
    CFG_NEEDLE_B   = 3'd1,
    CFG_NEEDLE_C   = 3'd2,
    CFG_NEEDLE_D   = 3'd3,
    CFG_NEEDLE_LEN = 3'd4
  } cfg_index_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_DONE  = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [NEEDLE_MAX*8-1:0] needle;
    logic [5:0]              length;
  } cfg_t;

  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  match_offset;
    logic         in_payload;
    logic [31:0]  flash_address;
    logic [4:0]   match_number;
    logic         limit_hit;
    logic         is_last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/bps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Needle and needle length registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module bps_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [2:0]       wr_index_i,
  input  wire logic [63:0]      wr_data_i,
  output bps_pkg::cfg_t         cfg_o
);

  logic [63:0] word_a_q, word_b_q, word_c_q, word_d_q;
  logic [5:0]  length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= '0;
      word_b_q <= '0;
      word_c_q <= '0;
      word_d_q <= '0;
      length_q <= 6'd1;
    end else if (wr_en_i) begin
      case (bps_pkg::cfg_index_e'(wr_index_i))
        bps_pkg::CFG_NEEDLE_A:   word_a_q <= wr_data_i;
        bps_pkg::CFG_NEEDLE_B:   word_b_q <= wr_data_i;
        bps_pkg::CFG_NEEDLE_C:   word_c_q <= wr_data_i;
        bps_pkg::CFG_NEEDLE_D:   word_d_q <= wr_data_i;
        bps_pkg::CFG_NEEDLE_LEN: length_q <= wr_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.needle = {word_d_q, word_c_q, word_b_q, word_a_q};
  assign cfg_o.length = length_q;

endmodule
`default_nettype wire

>>> rtl/core/bps_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_match
// Byte history, stream counters and the parallel needle compare; builds the
// result records caused by one accepted byte.
// ----------------------------------------------------------------------------
module bps_match (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  bps_pkg::cfg_t   cfg_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic [1:0]      push_count_o,
  output bps_pkg::result_t res0_o,
  output bps_pkg::result_t res1_o
);

  logic [7:0]  hist_q [bps_pkg::HIST_DEPTH];
  logic [7:0]  hist_d [bps_pkg::HIST_DEPTH];
  logic [31:0] seen_q, seen_d;
  logic [4:0]  total_q, total_d;
  logic [5:0]  fill_q, fill_d;
  logic        halted_q;

  logic [5:0]  len;
  logic [bps_pkg::NEEDLE_MAX-1:0] eq;
  logic        hit, limit;
  logic [31:0] pos;
  logic [8:0]  inblk, payoff;
  logic        pay;
  logic [31:0] flash;

  // clamp needle length to 1..NEEDLE_MAX
  always_comb begin
    if (cfg_i.length == 6'd0) begin
      len = 6'd1;
    end else if (cfg_i.length > bps_pkg::LEN_MAX) begin
      len = bps_pkg::LEN_MAX;
    end else begin
      len = cfg_i.length;
    end
  end

  always_comb begin
    hist_d[0] = data_byte_i;
    for (int i = 1; i < bps_pkg::HIST_DEPTH; i++) begin
      hist_d[i] = hist_q[i-1];
    end
  end

  assign seen_d = seen_q + 32'd1;
  assign fill_d = (fill_q < bps_pkg::FILL_FULL) ? fill_q + 6'd1 : fill_q;

  // needle byte k sits len-1-k places back from the newest byte
  always_comb begin
    for (int k = 0; k < bps_pkg::NEEDLE_MAX; k++) begin
      if (6'(k) < len) begin
        eq[k] = hist_d[5'(len - 6'd1 - 6'(k))] == cfg_i.needle[8*k +: 8];
      end else begin
        eq[k] = 1'b1;
      end
    end
  end

  assign hit     = (&eq) && (fill_d >= len);
  assign total_d = (hit && total_q < bps_pkg::TOTAL_SAT) ? total_q + 5'd1 : total_q;
  assign limit   = hit && ({3'b000, total_d} >= 8'(bps_pkg::MATCH_LIMIT));

  assign pos    = seen_d - {26'd0, len};
  assign inblk  = pos[8:0];
  assign pay    = (inblk >= bps_pkg::PAYLOAD_LO) && (inblk < bps_pkg::PAYLOAD_HI);
  assign payoff = inblk - bps_pkg::PAYLOAD_LO;
  assign flash  = pay ? bps_pkg::FLASH_BASE + {1'b0, pos[31:9], payoff[7:0]} : 32'd0;

  always_comb begin
    bps_pkg::result_t m, d;
    m.kind          = bps_pkg::KIND_MATCH;
    m.match_offset  = pos;
    m.in_payload    = pay;
    m.flash_address = flash;
    m.match_number  = total_d;
    m.limit_hit     = limit;
    m.is_last       = limit || !final_byte_i;
    d.kind          = bps_pkg::KIND_DONE;
    d.match_offset  = seen_d;
    d.in_payload    = 1'b0;
    d.flash_address = 32'd0;
    d.match_number  = total_d;
    d.limit_hit     = 1'b0;
    d.is_last       = 1'b1;
    res0_o = hit ? m : d;
    res1_o = d;
    if (halted_q) begin
      push_count_o = 2'd0;
    end else begin
      push_count_o = {1'b0, hit} + {1'b0, final_byte_i && !limit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !halted_q) begin
      for (int i = 0; i < bps_pkg::HIST_DEPTH; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      total_q  <= '0;
      fill_q   <= '0;
      halted_q <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        seen_q   <= '0;
        total_q  <= '0;
        fill_q   <= '0;
        halted_q <= 1'b0;
      end else if (!halted_q) begin
        seen_q   <= seen_d;
        total_q  <= total_d;
        fill_q   <= fill_d;
        halted_q <= limit;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bps_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_result_fifo
// Three-entry result queue; takes up to two records per cycle.
// ----------------------------------------------------------------------------
module bps_result_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  push_count_i,
  input  bps_pkg::result_t res0_i,
  input  bps_pkg::result_t res1_i,
  input  wire logic        pop_i,
  output logic             room_o,
  output logic             valid_o,
  output bps_pkg::result_t head_o
);

  bps_pkg::result_t mem_q [bps_pkg::FIFO_DEPTH];
  logic [1:0] rd_ptr_q, wr_ptr_q, count_q;
  logic [1:0] wr_next, wr_next2;
  logic       pop;

  function automatic logic [1:0] next_ptr(input logic [1:0] p);
    return (p == 2'(bps_pkg::FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop      = pop_i && valid_o;
  assign wr_next  = next_ptr(wr_ptr_q);
  assign wr_next2 = next_ptr(wr_next);
  assign room_o   = count_q <= 2'd1;
  assign valid_o  = count_q != 2'd0;
  assign head_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_count_i == 2'd2) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case (push_count_i)
        2'd1:    wr_ptr_q <= wr_next;
        2'd2:    wr_ptr_q <= wr_next2;
        default: ;
      endcase
      count_q <= count_q + push_count_i - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/byte_pattern_scanner_uf2_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_pattern_scanner_uf2_map
// Streaming needle search over a file with UF2 payload address mapping.
// ----------------------------------------------------------------------------
// output: the results of a byte enter the result queue at its transaction
// throughput: one byte per cycle, set by the combinational 32-byte history
//   compare; a byte giving two results needs two output transactions, and the
//   three-entry result queue accepts a byte whenever it holds at most one result
// reset: counters, fill count, halt flag and queue are cleared at once; needle
//   registers return to zero and needle length to 1; no clearing pass
// ----------------------------------------------------------------------------
module byte_pattern_scanner_uf2_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // byte stream in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte
  input  wire logic        s_axis_tlast_i,   // final_byte
  // result stream out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // match_offset, in_payload,
                                             // flash_address, match_number,
                                             // limit_hit, zero pad
  output logic             m_axis_tuser_o,   // result_kind
  output logic             m_axis_tlast_o    // is_last
);

  bps_pkg::cfg_t    cfg;
  bps_pkg::result_t res0, res1, head;
  logic [1:0]       push_count;
  logic             in_accept;
  logic             room;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  bps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // a byte transaction happens only while the queue can absorb two results
  assign s_axis_tready_o = room;
  assign in_accept       = s_axis_tvalid_i && room;

  bps_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (in_accept),
    .data_byte_i  (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .push_count_o (push_count),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  // nothing is pushed unless the byte transaction really happens
  logic [1:0] push_gated;
  assign push_gated = in_accept ? push_count : 2'd0;

  bps_result_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_gated),
    .res0_i       (res0),
    .res1_i       (res1),
    .pop_i        (m_axis_tready_i),
    .room_o       (room),
    .valid_o      (m_axis_tvalid_o),
    .head_o       (head)
  );

  // output packing, match_offset in the lowest bits and the zero pad on top
  assign m_axis_tdata_o = {1'b0, head.limit_hit, head.match_number, head.flash_address,
                           head.in_payload, head.match_offset};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.is_last;

endmodule
`default_nettype wire

>>> tb/byte_pattern_scanner_uf2_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_scanner_uf2_map_tb
// Streams files of bytes through the needle scanner and compares every
// match and end-of-scan report against an in-bench scanner model, across
// several needle settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module byte_pattern_scanner_uf2_map_tb;

  localparam int unsigned DIRECTED_BYTES  = 25;
  localparam int unsigned RANDOM_BYTES    = 1250;
  localparam int unsigned TAIL_BYTES      = 150;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned HOLD_CYCLES     = 240;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  // clock, reset and every block input start at a known value
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic [2:0]  cfg_index_i     = '0;
  logic [63:0] cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_ready_o;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [71:0] m_axis_tdata_o;   // match_offset, in_payload, flash_address,
                                 // match_number, limit_hit, zero pad
  logic        m_axis_tuser_o;   // result_kind
  logic        m_axis_tlast_o;   // is_last

  byte_pattern_scanner_uf2_map dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scanner model state, mirrors what the block should hold
  logic [bps_pkg::NEEDLE_MAX*8-1:0] needle_bits    = '0;
  logic [5:0]                       needle_len_reg = 6'd1;
  logic [7:0]                       history [bps_pkg::HIST_DEPTH];
  logic [31:0]                      bytes_seen;
  logic [4:0]                       match_total;
  logic                             halted;
  int unsigned                      fill_count;

  file_byte_t        byte_queue [$];         // bytes waiting for the driver
  bps_pkg::result_t  expected_results [$];   // reports the block still owes

  // run bookkeeping
  int unsigned bytes_queued    = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned files_closed    = 0;
  int unsigned settings_used   = 0;
  int unsigned reg_writes      = 0;
  int unsigned match_reports   = 0;
  int unsigned payload_reports = 0;
  int unsigned limit_reports   = 0;
  int unsigned done_reports    = 0;
  int unsigned error_count     = 0;
  int unsigned stall_cycles    = 0;

  // idling control: percent chance of a gap, and the long receiver hold-off
  int unsigned idle_pct  = 8;
  logic        hold_off  = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  logic        in_fire   = 1'b0;

  function automatic int unsigned used_needle_len();
    if (needle_len_reg == 6'd0) return 1;
    if (needle_len_reg > bps_pkg::LEN_MAX) return bps_pkg::NEEDLE_MAX;
    return needle_len_reg;
  endfunction

  function automatic logic [7:0] needle_byte(input int unsigned k);
    return needle_bits[8*k +: 8];
  endfunction

  // end of file: history, counters and halt flag go back to reset
  function automatic void clear_stream();
    for (int i = 0; i < bps_pkg::HIST_DEPTH; i++) history[i] = '0;
    bytes_seen  = '0;
    match_total = '0;
    halted      = 1'b0;
    fill_count  = 0;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] value);
    case (bps_pkg::cfg_index_e'(idx))
      bps_pkg::CFG_NEEDLE_A:   needle_bits[63:0]    = value;
      bps_pkg::CFG_NEEDLE_B:   needle_bits[127:64]  = value;
      bps_pkg::CFG_NEEDLE_C:   needle_bits[191:128] = value;
      bps_pkg::CFG_NEEDLE_D:   needle_bits[255:192] = value;
      bps_pkg::CFG_NEEDLE_LEN: needle_len_reg       = value[5:0];
      default: ;  // unknown index, no effect
    endcase
  endfunction

  // shift one byte into the history and queue the reports it should cause
  task automatic scan_byte(input logic [7:0] b, input logic last);
    bps_pkg::result_t r;
    int unsigned      len;
    logic             hit;
    logic             limit;
    logic [31:0]      pos;
    logic [8:0]       inblk;
    if (halted) begin
      // past the match limit: bytes vanish, the final byte just rearms
      if (last) clear_stream();
      return;
    end
    for (int i = bps_pkg::HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = b;
    bytes_seen = bytes_seen + 32'd1;
    if (fill_count < bps_pkg::HIST_DEPTH) fill_count++;
    len   = used_needle_len();
    limit = 1'b0;
    // no compare until the file holds a full needle's worth of bytes
    if (fill_count >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (history[len-1-k] != needle_byte(k)) hit = 1'b0;
      end
      if (hit) begin
        pos   = bytes_seen - 32'(len);
        inblk = pos[8:0];
        r.kind          = bps_pkg::KIND_MATCH;
        r.match_offset  = pos;
        r.in_payload    = (inblk >= bps_pkg::PAYLOAD_LO) && (inblk < bps_pkg::PAYLOAD_HI);
        // flash = base + block * 256 + offset into the payload
        r.flash_address = r.in_payload ?
                          bps_pkg::FLASH_BASE + 32'({pos[31:9], 8'h00}) +
                          32'(inblk - bps_pkg::PAYLOAD_LO) :
                          32'd0;
        if (match_total < bps_pkg::TOTAL_SAT) match_total = match_total + 5'd1;
        limit          = (match_total >= bps_pkg::MATCH_LIMIT);
        r.match_number = match_total;
        r.limit_hit    = limit;
        r.is_last      = limit || !last;
        expected_results.push_back(r);
        if (limit) halted = 1'b1;
      end
    end
    if (last) begin
      if (!limit) begin
        r.kind          = bps_pkg::KIND_DONE;
        r.match_offset  = bytes_seen;
        r.in_payload    = 1'b0;
        r.flash_address = '0;
        r.match_number  = match_total;
        r.limit_hit     = 1'b0;
        r.is_last       = 1'b1;
        expected_results.push_back(r);
      end
      clear_stream();
    end
  endtask

  initial clear_stream();

  // accepted transactions feed the model; needle writes update its copy
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      scan_byte(s_axis_tdata_i, s_axis_tlast_i);
      bytes_accepted++;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      apply_reg(cfg_index_i, cfg_data_i);
      reg_writes++;
    end
  end

  // byte driver: holds a byte until taken, otherwise idles or presents the next
  always @(negedge clk_i) begin
    file_byte_t fb;
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic       nxt_last;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    nxt_last  = s_axis_tlast_i;
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (byte_queue.size() > 0) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 17) - 1;
        end else begin
          fb        = byte_queue.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = fb.data;
          nxt_last  = fb.last;
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
    s_axis_tlast_i  <= nxt_last;
  end

  // result receiver: random stall bursts plus the long hold-off
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (!rst_ni || hold_off) begin
      nxt_ready = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(1, 17) - 1;
    end else begin
      nxt_ready = 1'b1;
    end
    m_axis_tready_i <= nxt_ready;
  end

  // result monitor: every report must match the oldest expectation
  always @(posedge clk_i) begin
    bps_pkg::result_t got;
    bps_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind          = bps_pkg::result_kind_e'(m_axis_tuser_o);
      got.match_offset  = m_axis_tdata_o[31:0];
      got.in_payload    = m_axis_tdata_o[32];
      got.flash_address = m_axis_tdata_o[64:33];
      got.match_number  = m_axis_tdata_o[69:65];
      got.limit_hit     = m_axis_tdata_o[70];
      got.is_last       = m_axis_tlast_o;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("[%0t] unexpected report: kind=%0d off=%0d num=%0d", $realtime,
                   got.kind, got.match_offset, got.match_number);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.match_offset !== want.match_offset ||
            got.in_payload !== want.in_payload ||
            got.flash_address !== want.flash_address ||
            got.match_number !== want.match_number ||
            got.limit_hit !== want.limit_hit || got.is_last !== want.is_last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("[%0t] report mismatch (kind off pay flash num lim last)", $realtime);
            $display("  expected %0d %0d %0d %h %0d %0d %0d", want.kind,
                     want.match_offset, want.in_payload, want.flash_address,
                     want.match_number, want.limit_hit, want.is_last);
            $display("  actual   %0d %0d %0d %h %0d %0d %0d", got.kind,
                     got.match_offset, got.in_payload, got.flash_address,
                     got.match_number, got.limit_hit, got.is_last);
          end
        end
      end
      if (got.kind == bps_pkg::KIND_DONE) begin
        done_reports++;
      end else begin
        match_reports++;
        if (got.in_payload) payload_reports++;
        if (got.limit_hit) limit_reports++;
      end
    end
  end

  // watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long receiver hold-off once a big file is queued, so the block backs up
  initial begin
    while (byte_queue.size() < 200) @(negedge clk_i);
    hold_off <= 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] data, input logic last);
    file_byte_t fb;
    fb.data = data;
    fb.last = last;
    byte_queue.push_back(fb);
    bytes_queued++;
    if (last) files_closed++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // everything sent and answered; a byte with no report may still be in flight
  task automatic wait_quiet();
    while (byte_queue.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // pick a needle setting, extremes and out-of-range lengths among them
  task automatic program_needle();
    logic [63:0] words [4];
    logic [7:0]  fill;
    logic [5:0]  len;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    fill = 8'($urandom);
    for (int w = 0; w < 4; w++) begin
      case (mode)
        0:       words[w] = '0;
        1:       words[w] = '1;
        2, 3:    words[w] = {8{fill}};   // repeated byte, overlapping matches
        default: words[w] = {$urandom, $urandom};
      endcase
    end
    case ($urandom_range(0, 9))
      0:       len = 6'd1;
      1:       len = 6'd2;
      2:       len = 6'd32;
      3:       len = 6'd0;                         // taken as one byte
      4:       len = 6'($urandom_range(33, 63));   // clipped to the maximum
      5, 6:    len = 6'($urandom_range(3, 8));
      default: len = 6'($urandom_range(1, 32));
    endcase
    write_reg(bps_pkg::CFG_NEEDLE_A, words[0]);
    write_reg(bps_pkg::CFG_NEEDLE_B, words[1]);
    write_reg(bps_pkg::CFG_NEEDLE_C, words[2]);
    write_reg(bps_pkg::CFG_NEEDLE_D, words[3]);
    write_reg(bps_pkg::CFG_NEEDLE_LEN, {$urandom, 26'($urandom), len});
    if ($urandom_range(0, 2) == 0)
      write_reg(bps_pkg::CFG_NEEDLE_LEN + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    settings_used++;
  endtask

  // random file with needle copies planted, some of them cut short
  task automatic queue_file(input int unsigned flen, input int unsigned plant_pct,
                            input bit close_it);
    int unsigned nlen;
    int unsigned cnt;
    int unsigned i;
    logic [7:0]  b;
    nlen = used_needle_len();
    i    = 0;
    while (i < flen) begin
      if ($urandom_range(0, 99) < plant_pct) begin
        cnt = nlen;
        if (nlen > 1 && $urandom_range(0, 4) == 0) cnt = $urandom_range(1, nlen - 1);
        for (int k = 0; k < cnt && i < flen; k++) begin
          push_byte(needle_byte(k), close_it && (i == flen - 1));
          i++;
        end
      end else begin
        b = $urandom_range(0, 1) ? 8'($urandom) : needle_byte($urandom_range(0, nlen - 1));
        push_byte(b, close_it && (i == flen - 1));
        i++;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned nfiles;
    int unsigned flen;
    bit          close_it;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset needle is a single zero byte
    push_byte(8'h00, 1'b1);                 // match on the final byte, then done
    push_byte(8'hFF, 1'b1);                 // one-byte file, no match
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < 16; i++) push_byte(8'h00, 1'b0);   // sixteenth hits the limit
    push_byte(8'h00, 1'b0);                 // halted, ignored
    push_byte(8'hAB, 1'b0);
    push_byte(8'hFF, 1'b1);                 // final byte ends the file silently
    push_byte(8'h00, 1'b1);                 // scanner rearmed for the next file

    // random phases, each under a fresh needle setting
    phase = 0;
    while (bytes_queued < DIRECTED_BYTES + RANDOM_BYTES - TAIL_BYTES) begin
      wait_quiet();
      program_needle();
      idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 15);
      if (phase == 2) begin
        // one file past a full UF2 block so later blocks map too
        queue_file($urandom_range(540, 600), 2, 1'b1);
      end else begin
        nfiles = $urandom_range(2, 8);
        for (int f = 0; f < nfiles; f++) begin
          flen     = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
                                                   $urandom_range(1, 48);
          // sometimes leave the phase's last file open across the setting change
          close_it = (f < nfiles - 1) || ($urandom_range(0, 4) != 0);
          queue_file(flen, $urandom_range(0, 30), close_it);
        end
      end
      phase++;
    end

    // closing stretch at full rate on both streams
    wait_quiet();
    program_needle();
    idle_pct <= 0;
    do begin
      queue_file($urandom_range(20, 60), $urandom_range(5, 30), 1'b1);
    end while (bytes_queued < DIRECTED_BYTES + RANDOM_BYTES);

    wait_quiet();
    error_count += expected_results.size();
    $display("covered %0d bytes in %0d closed files under %0d needle settings (%0d reg writes)",
             bytes_accepted, files_closed, settings_used, reg_writes);
    $display("reports: %0d matches (%0d in payload, %0d at limit), %0d end-of-scan",
             match_reports, payload_reports, limit_reports, done_reports);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
